// ----- hw/rtl/aes128_block_cipher_macros.svh -----
// Assertion macros for the AES-128 block cipher.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH
`ifndef ASSERT_OFF
`define AES128_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES128_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AES128_ASSERT(lbl, prop, msg)
`define AES128_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/aes128_pkg.sv -----
// Shared constants, S-box tables and key-schedule functions for the AES-128 cipher.
package aes128_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 4'd1;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned ROW_AW     = 4;
  localparam logic [ROW_AW-1:0] LAST_ROW = 4'd10;

  localparam logic [7:0] FWD_SBOX [0:255] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [0:255] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  function automatic logic [7:0] rcon(input logic [ROW_AW-1:0] k);
    logic [7:0] r;
    case (k)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1B;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Next round-key row from the previous one; row k uses rcon(k).
  function automatic logic [127:0] key_step(input logic [127:0] prev,
                                            input logic [ROW_AW-1:0] k);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(k), 24'h0};
    n0 = prev[127:96] ^ t;
    n1 = prev[95:64] ^ n0;
    n2 = prev[63:32] ^ n1;
    n3 = prev[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ----- hw/rtl/aes128_round.sv -----
// One AES round, forward or inverse, or a bare round-key add, on a 128-bit state.
module aes128_round (
  input  logic [127:0] st_in,
  input  logic [127:0] rkey_in,
  input  logic         decrypt,
  input  logic         add_only,
  input  logic         last,
  output logic [127:0] st_out
);

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  logic [127:0] sub_f, shf_f, mix_f, shf_i, sub_i, add_i, mix_i;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub_f[127-8*i -: 8] = aes128_pkg::FWD_SBOX[get_byte(st_in, i)];
    end
    // Row r of column c takes column c+r forward, c-r inverse.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf_f[127-8*(c*4+r) -: 8] = get_byte(sub_f, ((c + r) % 4) * 4 + r);
        shf_i[127-8*(c*4+r) -: 8] = get_byte(st_in, ((c + 3*r) % 4) * 4 + r);
      end
    end
    for (int i = 0; i < 16; i++) begin
      sub_i[127-8*i -: 8] = aes128_pkg::INV_SBOX[get_byte(shf_i, i)];
    end
    add_i = sub_i ^ rkey_in;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
        logic [7:0] c0, c1, c2, c3;
        a0 = get_byte(shf_f, c*4 + r);
        a1 = get_byte(shf_f, c*4 + (r+1)%4);
        a2 = get_byte(shf_f, c*4 + (r+2)%4);
        a3 = get_byte(shf_f, c*4 + (r+3)%4);
        mix_f[127-8*(c*4+r) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        b0 = get_byte(add_i, c*4 + r);
        b1 = get_byte(add_i, c*4 + (r+1)%4);
        b2 = get_byte(add_i, c*4 + (r+2)%4);
        b3 = get_byte(add_i, c*4 + (r+3)%4);
        // c = x2, x4, x8 multiples; 14=8+4+2, 11=8+2+1, 13=8+4+1, 9=8+1
        c0 = xt(b0) ^ xt(xt(b0)) ^ xt(xt(xt(b0)));
        c1 = xt(xt(xt(b1))) ^ xt(b1) ^ b1;
        c2 = xt(xt(xt(b2))) ^ xt(xt(b2)) ^ b2;
        c3 = xt(xt(xt(b3))) ^ b3;
        mix_i[127-8*(c*4+r) -: 8] = c0 ^ c1 ^ c2 ^ c3;
      end
    end
    if (add_only) begin
      st_out = st_in ^ rkey_in;
    end else if (decrypt) begin
      st_out = last ? add_i : mix_i;
    end else begin
      st_out = (last ? shf_f : mix_f) ^ rkey_in;
    end
  end

endmodule

// ----- hw/rtl/aes128_block_cipher.sv -----
// AES-128 block cipher top level: key registers, round-key memory, round sequencer.
// Each block takes the initial key add plus ten rounds, one per cycle through a single
// round unit, then a load into the output register. The sequencer returns to idle before
// the next block, so blocks do not overlap; a key write first runs the expansion, one
// round-key row per cycle into the memory, before the next block is taken.
// Reset (rst_n, synchronous, active low): keys zero, keys not expanded, output empty.
`include "aes128_block_cipher_macros.svh"
module aes128_block_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [63:0]                       in_block_high,
  input  logic [63:0]                       in_block_low,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [63:0]                       out_result_high,
  output logic [63:0]                       out_result_low,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_RUN, S_DONE} state_t;

  localparam logic [aes128_pkg::ROW_AW-1:0] ROW_ZERO = '0;
  localparam logic [aes128_pkg::ROW_AW-1:0] ROW_ONE  = 4'd1;

  state_t       state_r;
  logic         keys_ready_r;
  logic [63:0]  key_high_r, key_low_r;
  logic [aes128_pkg::ROW_AW-1:0] exp_cnt_r, cnt_r, rd_addr;
  logic [127:0] exp_row_r, exp_row;
  logic [127:0] st_r, st_nxt, rk_r;
  logic         dec_r;
  logic         out_valid_r;
  logic [63:0]  res_high_r, res_low_r;
  logic         in_accept, cfg_hit, mem_we, out_load;

  // Round-key store: one 128-bit row per round, rows 0 to 10.
  logic [127:0] rk_mem [0:10];

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid &&
                     (cfg_index == aes128_pkg::REG_KEY_HIGH ||
                      cfg_index == aes128_pkg::REG_KEY_LOW);
  // Take a block only when idle with the schedule in the memory.
  assign in_stall  = !(state_r == S_IDLE && keys_ready_r);
  assign in_accept = in_valid && !in_stall;
  // Move the finished block out once the output register is free.
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign out_valid       = out_valid_r;
  assign out_result_high = res_high_r;
  assign out_result_low  = res_low_r;

  // Row 0 is the key itself; later rows chain from the previous row.
  assign exp_row = (exp_cnt_r == ROW_ZERO) ? {key_high_r, key_low_r}
                                           : aes128_pkg::key_step(exp_row_r, exp_cnt_r);
  assign mem_we  = (state_r == S_EXPAND);

  // Fetch one row ahead: the round at count k uses the row fetched at count k-1.
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = in_mode ? aes128_pkg::LAST_ROW : ROW_ZERO;
    end else if (dec_r) begin
      rd_addr = (cnt_r < aes128_pkg::LAST_ROW) ? (aes128_pkg::LAST_ROW - ROW_ONE - cnt_r)
                                               : ROW_ZERO;
    end else begin
      rd_addr = (cnt_r < aes128_pkg::LAST_ROW) ? (cnt_r + ROW_ONE) : aes128_pkg::LAST_ROW;
    end
  end

  // Writes happen only while expanding and reads matter only when idle or running,
  // so the state machine keeps the two apart and no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_mem[exp_cnt_r] <= exp_row;
    end
    rk_r <= rk_mem[rd_addr];
  end

  aes128_round u_round (
    .st_in     (st_r),
    .rkey_in   (rk_r),
    .decrypt   (dec_r),
    .add_only  (cnt_r == ROW_ZERO),
    .last      (cnt_r == aes128_pkg::LAST_ROW),
    .st_out    (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      key_high_r   <= '0;
      key_low_r    <= '0;
      exp_cnt_r    <= '0;
      cnt_r        <= '0;
      dec_r        <= 1'b0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg_index)
          aes128_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
          aes128_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
          default: ;
        endcase
      end
      // A key write invalidates the schedule; a finished expansion validates it.
      if (cfg_hit) begin
        keys_ready_r <= 1'b0;
      end else if (state_r == S_EXPAND && exp_cnt_r == aes128_pkg::LAST_ROW) begin
        keys_ready_r <= 1'b1;
      end
      // Load the output beat, or drop it once taken.
      if (out_load) begin
        res_high_r  <= st_r[127:64];
        res_low_r   <= st_r[63:0];
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!keys_ready_r) begin
            exp_cnt_r <= '0;
            state_r   <= S_EXPAND;
          end else if (in_accept) begin
            st_r    <= {in_block_high, in_block_low};
            dec_r   <= in_mode;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_EXPAND: begin
          exp_row_r <= exp_row;
          exp_cnt_r <= exp_cnt_r + ROW_ONE;
          // A key write mid-expansion restarts it from row 0.
          if (cfg_hit || exp_cnt_r == aes128_pkg::LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          st_r  <= st_nxt;
          cnt_r <= cnt_r + ROW_ONE;
          if (cnt_r == aes128_pkg::LAST_ROW) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `AES128_ASSERT(a_accept_keys, !in_accept || keys_ready_r, "block accepted without keys")
  `AES128_ASSERT_NEXT(a_accept_run, in_accept, state_r == S_RUN, "accepted block not running")
  `AES128_ASSERT_NEXT(a_cfg_clears, cfg_hit, !keys_ready_r, "key write left keys ready")
  `AES128_ASSERT(a_no_wr_in_run, state_r != S_RUN || !mem_we, "key memory written mid-block")

endmodule

// ----- sim/tb_aes128_block_cipher.sv -----
// Self-checking testbench for the AES-128 block cipher, with known vectors and random traffic.
`timescale 1ns / 1ps
module tb_aes128_block_cipher;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 40;   // slack after the last result is checked
  localparam int unsigned KEY_SETTLE  = 30;   // idle gap before a key write
  localparam int unsigned RAND_BLOCKS = 1800;
  localparam logic [aes128_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 4'd15;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic { ROW_KEY, ROW_BLOCK } row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [aes128_pkg::CFG_IDX_W-1:0]  idx;
    logic                              mode;
    logic [127:0]                      data;     // key half in the low 64 bits, or the block
    logic                              has_exp;
    logic [127:0]                      exp;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_mode;
  logic [63:0]                      in_block_high;
  logic [63:0]                      in_block_low;
  logic                             out_valid;
  logic                             out_stall;
  logic [63:0]                      out_result_high;
  logic [63:0]                      out_result_low;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [aes128_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                      cfg_data;

  // Shadow copy of the key registers, updated on every accepted key beat
  logic [63:0]  key_hi_shadow;
  logic [63:0]  key_lo_shadow;
  logic [127:0] pending_results[$];
  int unsigned  cycle_count;
  int unsigned  error_count;
  int unsigned  blocks_sent;
  int unsigned  results_seen;
  int unsigned  key_writes;
  int unsigned  burst_left;
  bit           no_gaps;

  aes128_block_cipher u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // GF(2^8) doubling and general multiply
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = gf_double(x);
    end
    return acc;
  endfunction

  // Full AES-128 on one block: expand the key, then run the forward or inverse rounds.
  // Byte i of the state is row i%4 of column i/4; byte 0 is the block's top byte.
  function automatic logic [127:0] aes_block(input logic mode, input logic [127:0] blk,
                                             input logic [127:0] key);
    logic [31:0]  w [44];
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a [4];
    logic [7:0]   cf [4];
    logic [31:0]  tmp;
    logic [7:0]   rc;
    logic [127:0] res;
    int           rnd;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      tmp = w[i-1];
      if (i % 4 == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {aes128_pkg::FWD_SBOX[tmp[31:24]], aes128_pkg::FWD_SBOX[tmp[23:16]],
               aes128_pkg::FWD_SBOX[tmp[15:8]], aes128_pkg::FWD_SBOX[tmp[7:0]]}
              ^ {rc, 24'h0};
        rc = gf_double(rc);
      end
      w[i] = w[i-4] ^ tmp;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (mode == MODE_ENC) cf = '{8'h02, 8'h03, 8'h01, 8'h01};
    else                  cf = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    rnd = (mode == MODE_ENC) ? 0 : aes128_pkg::NUM_ROUNDS;
    for (int i = 0; i < 16; i++) s[i] ^= w[rnd*4 + i/4][31-8*(i%4) -: 8];
    for (int step = 1; step <= aes128_pkg::NUM_ROUNDS; step++) begin
      rnd = (mode == MODE_ENC) ? step : aes128_pkg::NUM_ROUNDS - step;
      // Row shift, then byte substitution (the two commute)
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[c*4+r] = s[((c + ((mode == MODE_ENC) ? r : 3*r)) & 3)*4 + r];
      for (int i = 0; i < 16; i++)
        s[i] = (mode == MODE_ENC) ? aes128_pkg::FWD_SBOX[t[i]] : aes128_pkg::INV_SBOX[t[i]];
      if (mode == MODE_ENC) begin
        if (step != aes128_pkg::NUM_ROUNDS)
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[c*4+r];
            for (int r = 0; r < 4; r++)
              s[c*4+r] = gf_times(a[r], cf[0]) ^ gf_times(a[(r+1)&3], cf[1]) ^
                         gf_times(a[(r+2)&3], cf[2]) ^ gf_times(a[(r+3)&3], cf[3]);
          end
        for (int i = 0; i < 16; i++) s[i] ^= w[rnd*4 + i/4][31-8*(i%4) -: 8];
      end else begin
        for (int i = 0; i < 16; i++) s[i] ^= w[rnd*4 + i/4][31-8*(i%4) -: 8];
        if (rnd != 0)
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[c*4+r];
            for (int r = 0; r < 4; r++)
              s[c*4+r] = gf_times(a[r], cf[0]) ^ gf_times(a[(r+1)&3], cf[1]) ^
                         gf_times(a[(r+2)&3], cf[2]) ^ gf_times(a[(r+3)&3], cf[3]);
          end
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one block; hold it until a beat goes through, then queue its expected result.
  task automatic send_block(input logic mode, input logic [127:0] blk,
                            input logic has_exp, input logic [127:0] exp);
    @(negedge clk);
    in_valid      = 1'b1;
    in_mode       = mode;
    in_block_high = blk[127:64];
    in_block_low  = blk[63:0];
    do @(posedge clk); while (in_stall);
    pending_results.push_back(has_exp ? exp
                              : aes_block(mode, blk, {key_hi_shadow, key_lo_shadow}));
    blocks_sent++;
    // Bursts of random length, random gaps between them unless no_gaps is set
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if (!no_gaps) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  // Key writes happen only with the block idle: drain, let it settle, then write.
  task automatic write_key(input logic [aes128_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (KEY_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == aes128_pkg::REG_KEY_HIGH) key_hi_shadow = value;
    else if (idx == aes128_pkg::REG_KEY_LOW) key_lo_shadow = value;
    key_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result checker: every output beat is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $time, out_result_high, out_result_low);
        error_count++;
      end else begin
        if (out_result_high !== pending_results[0][127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   pending_results[0][127:64], out_result_high);
          error_count++;
        end
        if (out_result_low !== pending_results[0][63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   pending_results[0][63:0], out_result_low);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern steps through none, light and heavy in turn, plus
  // two long hold-offs so the cipher fills and pushes back on its input.
  initial begin
    int unsigned hold_left;
    int unsigned pattern;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle_count == 5000 || cycle_count == 60000) hold_left = 600;
      pattern = (cycle_count / 256) % 3;
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (pattern == 0) begin
        out_stall = 1'b0;
      end else if (pattern == 1) begin
        out_stall = ($urandom_range(0, 3) == 0);
      end else begin
        out_stall = ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t   rows[$];
    logic [127:0] blk;
    logic [63:0]  kv;
    int unsigned  pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_ENC;
    in_block_high = '0;
    in_block_low  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = aes128_pkg::REG_KEY_HIGH;
    cfg_data      = '0;
    key_hi_shadow = '0;
    key_lo_shadow = '0;
    cycle_count   = 0;
    error_count   = 0;
    blocks_sent   = 0;
    results_seen  = 0;
    key_writes    = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: known vectors typed in, the rest left to the predictor
    rows = '{
      // Blocks before any key write use the all-zero reset key
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC, 128'h0, 1'b1,
        128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_DEC,
        128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC, {128{1'b1}}, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_DEC, {128{1'b1}}, 1'b0, 128'h0},
      // Only the high half written: low half stays zero
      '{ROW_KEY, aes128_pkg::REG_KEY_HIGH, MODE_ENC, 128'h0001020304050607, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC,
        128'h00112233445566778899aabbccddeeff, 1'b0, 128'h0},
      '{ROW_KEY, aes128_pkg::REG_KEY_LOW, MODE_ENC, 128'h08090a0b0c0d0e0f, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC,
        128'h00112233445566778899aabbccddeeff, 1'b1,
        128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_DEC,
        128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
        128'h00112233445566778899aabbccddeeff},
      // Write to an unused index: ignored, key unchanged
      '{ROW_KEY, REG_UNUSED_TOP, MODE_ENC, {64'h0, {64{1'b1}}}, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC,
        128'h00112233445566778899aabbccddeeff, 1'b1,
        128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      // All-ones key
      '{ROW_KEY, aes128_pkg::REG_KEY_HIGH, MODE_ENC, {64'h0, {64{1'b1}}}, 1'b0, 128'h0},
      '{ROW_KEY, aes128_pkg::REG_KEY_LOW, MODE_ENC, {64'h0, {64{1'b1}}}, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC, 128'h0, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_DEC, 128'h0, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC, {128{1'b1}}, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_DEC, {128{1'b1}}, 1'b0, 128'h0},
      // Back to the zero key
      '{ROW_KEY, aes128_pkg::REG_KEY_HIGH, MODE_ENC, 128'h0, 1'b0, 128'h0},
      '{ROW_KEY, aes128_pkg::REG_KEY_LOW, MODE_ENC, 128'h0, 1'b0, 128'h0},
      '{ROW_BLOCK, aes128_pkg::REG_KEY_HIGH, MODE_ENC, 128'h0, 1'b1,
        128'h66e94bd4ef8a2c3b884cfa59ca342b2e}
    };
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_KEY) write_key(rows[i].idx, rows[i].data[63:0]);
      else send_block(rows[i].mode, rows[i].data, rows[i].has_exp, rows[i].exp);
    end

    // Random part: new key every ~150 blocks, extremes among the keys and blocks
    for (int n = 0; n < RAND_BLOCKS; n++) begin
      if (n % 150 == 0) begin
        pick = (n / 150) % 4;
        kv = (pick == 0) ? 64'h0 : (pick == 1) ? {64{1'b1}} : rand64();
        write_key(aes128_pkg::REG_KEY_HIGH, kv);
        if ($urandom_range(0, 3) != 0) write_key(aes128_pkg::REG_KEY_LOW, rand64());
        if ($urandom_range(0, 2) == 0)
          write_key(aes128_pkg::CFG_IDX_W'($urandom_range(aes128_pkg::REG_KEY_LOW + 1,
                                                          REG_UNUSED_TOP)), rand64());
      end
      no_gaps = (n >= 600 && n < 900);
      pick = $urandom_range(0, 19);
      blk = (pick == 0) ? 128'h0 : (pick == 1) ? {128{1'b1}} : {rand64(), rand64()};
      send_block(logic'($urandom_range(0, 1)), blk, 1'b0, 128'h0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d blocks in both directions over %0d key writes, %0d results checked.",
             blocks_sent, key_writes, results_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
